// ----- rtl/ntm_pkg.sv -----
// Shared types and constants for the NCC template matcher.
`default_nettype none

package ntm_pkg;

    localparam logic CMD_TEMPLATE = 1'b0;
    localparam logic CMD_IMAGE    = 1'b1;

    localparam logic [7:0] CFG_TEMPLATE_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_TEMPLATE_HEIGHT = 8'd1;
    localparam logic [7:0] CFG_IMAGE_WIDTH     = 8'd2;
    localparam logic [7:0] CFG_IMAGE_HEIGHT    = 8'd3;

    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 16;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic [9:0]         pos_x;
        logic [11:0]        pos_y;
        logic               flat;
        logic               last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_CALC,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_RESULT
    } ntm_state_t;

    typedef struct packed {
        logic accept;
        logic sweep;
        logic calc;
        logic diff;
        logic mul;
        logic div;
        logic sqrt;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic win;
        logic sweep_done;
        logic flat;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ntm_datapath.sv -----
// Datapath: config, stores, window sweep, products, division and square root.
`default_nettype none

module ntm_datapath import ntm_pkg::*; #(
    parameter int MAX_TEMPLATE_WIDTH  = 16,
    parameter int MAX_TEMPLATE_HEIGHT = 16,
    parameter int MAX_IMAGE_WIDTH     = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire in_item_t    s_item,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts,
    output out_item_t        res
);

    localparam int TS_DEPTH = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
    localparam int LB_DEPTH = MAX_TEMPLATE_HEIGHT * MAX_IMAGE_WIDTH;
    localparam int TSAW = (TS_DEPTH > 1) ? $clog2(TS_DEPTH) : 1;
    localparam int LBAW = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;
    localparam int NB   = $clog2(TS_DEPTH + 1);
    localparam int TWW  = $clog2(MAX_TEMPLATE_WIDTH + 1);
    localparam int THW  = $clog2(MAX_TEMPLATE_HEIGHT + 1);
    localparam int RSW  = (MAX_TEMPLATE_HEIGHT > 1) ? $clog2(MAX_TEMPLATE_HEIGHT) : 1;
    localparam int CW   = $clog2(MAX_IMAGE_WIDTH);
    localparam int IWW  = CW + 1;
    localparam int SUMW = NB + 8;
    localparam int SQW  = NB + 16;
    localparam int PW   = 2 * NB + 16;
    localparam int ITW  = $clog2(PW);

    // configuration
    logic [4:0]  tw_cfg_reg, th_cfg_reg;
    logic [10:0] iw_cfg_reg;
    logic [11:0] ih_cfg_reg;

    logic [TWW-1:0] tw_eff;
    logic [THW-1:0] th_eff;
    logic [IWW-1:0] iw_eff;
    logic [11:0]    ih_eff;
    logic [NB-1:0]  n_eff;

    assign tw_eff = (tw_cfg_reg == 5'd0) ? TWW'(1) :
                    (32'(tw_cfg_reg) > MAX_TEMPLATE_WIDTH) ? TWW'(MAX_TEMPLATE_WIDTH) :
                    TWW'(tw_cfg_reg);
    assign th_eff = (th_cfg_reg == 5'd0) ? THW'(1) :
                    (32'(th_cfg_reg) > MAX_TEMPLATE_HEIGHT) ? THW'(MAX_TEMPLATE_HEIGHT) :
                    THW'(th_cfg_reg);
    assign iw_eff = (iw_cfg_reg == 11'd0) ? IWW'(1) :
                    (32'(iw_cfg_reg) > MAX_IMAGE_WIDTH) ? IWW'(MAX_IMAGE_WIDTH) :
                    IWW'(iw_cfg_reg);
    assign ih_eff = (ih_cfg_reg == 12'd0) ? 12'd1 : ih_cfg_reg;
    assign n_eff  = NB'(tw_eff) * NB'(th_eff);

    // template and frame position
    logic [NB-1:0]   tcount_reg;
    logic [SUMW-1:0] tsum_reg;
    logic [SQW-1:0]  tsq_reg;
    logic [CW-1:0]   col_reg;
    logic [11:0]     row_reg;
    logic [RSW-1:0]  rslot_reg;

    logic tfull, col_end, row_end, win, is_img, ts_we, lb_we;
    assign tfull   = tcount_reg >= n_eff;
    assign col_end = (32'(col_reg) + 1) >= 32'(iw_eff);
    assign row_end = (32'(row_reg) + 1) >= 32'(ih_eff);
    assign is_img  = s_item.cmd == CMD_IMAGE;
    assign win     = is_img && tfull && ((32'(col_reg) + 1) >= 32'(tw_eff)) &&
                     ((32'(row_reg) + 1) >= 32'(th_eff));
    assign ts_we   = cmd.accept && !is_img && !tfull;
    assign lb_we   = cmd.accept && is_img;

    // memories
    logic [7:0] ts_mem_reg [TS_DEPTH];
    logic [7:0] lb_mem_reg [LB_DEPTH];
    logic [7:0] ts_rdata_reg, lb_rdata_reg;
    logic [TSAW-1:0] ts_waddr, ts_raddr;
    logic [LBAW-1:0] lb_waddr, lb_raddr;

    // sweep
    logic [TWW-1:0]  sw_tx_reg;
    logic [THW-1:0]  sw_ty_reg;
    logic [RSW-1:0]  sw_rs_reg;
    logic [TSAW-1:0] sw_tidx_reg;
    logic [CW-1:0]   x0_reg;
    logic [11:0]     y0_reg;
    logic            last_reg, iss_reg, rdv_reg;
    logic [SUMW-1:0] acc_sw_reg;
    logic [SQW-1:0]  acc_sww_reg, acc_stw_reg;
    logic [RSW-1:0]  start_slot;

    assign ts_waddr = tcount_reg[TSAW-1:0];
    assign lb_waddr = LBAW'(32'(rslot_reg) * MAX_IMAGE_WIDTH + 32'(col_reg));
    assign ts_raddr = sw_tidx_reg;
    assign lb_raddr = LBAW'(32'(sw_rs_reg) * MAX_IMAGE_WIDTH + 32'(x0_reg) + 32'(sw_tx_reg));
    assign start_slot = ((32'(rslot_reg) + 1) >= 32'(th_eff)) ?
                        RSW'(32'(rslot_reg) + 1 - 32'(th_eff)) :
                        RSW'(32'(rslot_reg) + 1 + MAX_TEMPLATE_HEIGHT - 32'(th_eff));

    always_ff @(posedge aclk) begin
        if (ts_we) begin
            ts_mem_reg[ts_waddr] <= s_item.pixel;
        end
        ts_rdata_reg <= ts_mem_reg[ts_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lb_we) begin
            lb_mem_reg[lb_waddr] <= s_item.pixel;
        end
        lb_rdata_reg <= lb_mem_reg[lb_raddr];
    end

    // score arithmetic
    logic [PW-1:0] p_nstw_reg, p_stsw_reg, p_nstt_reg, p_stst_reg, p_nsww_reg, p_swsw_reg;
    logic [PW:0]   numd;
    logic [PW-1:0] mag, vt, vw;
    logic          neg_reg, flat_reg;
    logic [2*PW-1:0] ma_reg, mc_reg, acc1_reg, acc2_reg, acc1_next, acc2_next;
    logic [PW-1:0]   mb_reg, md_reg;
    logic [ITW-1:0]  iter_reg;
    logic [2*PW:0]   rem_reg, rem_sub;
    logic [2*PW-1:0] pden_reg;
    logic            ge;
    logic [DIV_STEPS-1:0] d_reg;
    logic [15:0]     q_reg, sbit_reg, q_try;
    logic [15:0]     score;

    assign numd = {1'b0, p_nstw_reg} - {1'b0, p_stsw_reg};
    assign mag  = numd[PW] ? PW'(-numd) : numd[PW-1:0];
    assign vt   = p_nstt_reg - p_stst_reg;
    assign vw   = p_nsww_reg - p_swsw_reg;

    assign acc1_next = acc1_reg + (mb_reg[0] ? ma_reg : '0);
    assign acc2_next = acc2_reg + (md_reg[0] ? mc_reg : '0);

    assign ge      = rem_reg >= {1'b0, pden_reg};
    assign rem_sub = ge ? (rem_reg - {1'b0, pden_reg}) : rem_reg;
    assign q_try   = q_reg | sbit_reg;

    always_comb begin
        if (flat_reg) begin
            score = 16'd0;
        end else if (neg_reg) begin
            score = 16'(17'd0 - {1'b0, q_reg});
        end else begin
            score = q_reg[15] ? 16'h7FFF : q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_cfg_reg <= 5'd8;
            th_cfg_reg <= 5'd8;
            iw_cfg_reg <= 11'd640;
            ih_cfg_reg <= 12'd480;
            tcount_reg <= '0;
            tsum_reg   <= '0;
            tsq_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            rslot_reg  <= '0;
            iss_reg    <= 1'b0;
            rdv_reg    <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_TEMPLATE_WIDTH) begin
                tw_cfg_reg <= cfg_data[4:0];
            end
            if (cfg_index == CFG_TEMPLATE_HEIGHT) begin
                th_cfg_reg <= cfg_data[4:0];
            end
            if (cfg_index == CFG_IMAGE_WIDTH) begin
                iw_cfg_reg <= cfg_data[10:0];
            end
            if (cfg_index == CFG_IMAGE_HEIGHT) begin
                ih_cfg_reg <= cfg_data[11:0];
            end
            if (cfg_index == CFG_TEMPLATE_WIDTH || cfg_index == CFG_TEMPLATE_HEIGHT) begin
                tcount_reg <= '0;
                tsum_reg   <= '0;
                tsq_reg    <= '0;
            end
            if (cfg_index <= CFG_IMAGE_HEIGHT) begin
                col_reg   <= '0;
                row_reg   <= '0;
                rslot_reg <= '0;
            end
        end else begin
            if (ts_we) begin
                tcount_reg <= tcount_reg + NB'(1);
                tsum_reg   <= tsum_reg + SUMW'(s_item.pixel);
                tsq_reg    <= tsq_reg + SQW'(16'(s_item.pixel) * 16'(s_item.pixel));
            end
            if (lb_we) begin
                if (col_end) begin
                    col_reg <= '0;
                    if (row_end) begin
                        row_reg   <= '0;
                        rslot_reg <= '0;
                    end else begin
                        row_reg   <= row_reg + 12'd1;
                        rslot_reg <= (32'(rslot_reg) == MAX_TEMPLATE_HEIGHT - 1) ? '0 :
                                     rslot_reg + RSW'(1);
                    end
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
                if (win) begin
                    iss_reg <= 1'b1;
                end
            end
            if (cmd.sweep) begin
                rdv_reg <= iss_reg;
                if (iss_reg && sw_tx_reg == tw_eff - TWW'(1) &&
                        sw_ty_reg == th_eff - THW'(1)) begin
                    iss_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lb_we && win) begin
            x0_reg      <= CW'(32'(col_reg) + 1 - 32'(tw_eff));
            y0_reg      <= 12'(32'(row_reg) + 1 - 32'(th_eff));
            last_reg    <= col_end && row_end;
            sw_tx_reg   <= '0;
            sw_ty_reg   <= '0;
            sw_tidx_reg <= '0;
            sw_rs_reg   <= start_slot;
            acc_sw_reg  <= '0;
            acc_sww_reg <= '0;
            acc_stw_reg <= '0;
        end
        if (cmd.sweep) begin
            if (iss_reg) begin
                sw_tidx_reg <= sw_tidx_reg + TSAW'(1);
                if (sw_tx_reg == tw_eff - TWW'(1)) begin
                    sw_tx_reg <= '0;
                    sw_ty_reg <= sw_ty_reg + THW'(1);
                    sw_rs_reg <= (32'(sw_rs_reg) == MAX_TEMPLATE_HEIGHT - 1) ? '0 :
                                 sw_rs_reg + RSW'(1);
                end else begin
                    sw_tx_reg <= sw_tx_reg + TWW'(1);
                end
            end
            if (rdv_reg) begin
                acc_sw_reg  <= acc_sw_reg + SUMW'(lb_rdata_reg);
                acc_sww_reg <= acc_sww_reg +
                               SQW'(16'(lb_rdata_reg) * 16'(lb_rdata_reg));
                acc_stw_reg <= acc_stw_reg +
                               SQW'(16'(lb_rdata_reg) * 16'(ts_rdata_reg));
            end
        end
        if (cmd.calc) begin
            p_nstw_reg <= PW'(n_eff) * PW'(acc_stw_reg);
            p_stsw_reg <= PW'(tsum_reg) * PW'(acc_sw_reg);
            p_nstt_reg <= PW'(n_eff) * PW'(tsq_reg);
            p_stst_reg <= PW'(tsum_reg) * PW'(tsum_reg);
            p_nsww_reg <= PW'(n_eff) * PW'(acc_sww_reg);
            p_swsw_reg <= PW'(acc_sw_reg) * PW'(acc_sw_reg);
        end
        if (cmd.diff) begin
            neg_reg  <= numd[PW];
            flat_reg <= (vt == '0) || (vw == '0);
            ma_reg   <= (2*PW)'(mag);
            mb_reg   <= mag;
            mc_reg   <= (2*PW)'(vt);
            md_reg   <= vw;
            acc1_reg <= '0;
            acc2_reg <= '0;
            iter_reg <= '0;
        end
        if (cmd.mul) begin
            acc1_reg <= acc1_next;
            acc2_reg <= acc2_next;
            ma_reg   <= ma_reg << 1;
            mc_reg   <= mc_reg << 1;
            mb_reg   <= mb_reg >> 1;
            md_reg   <= md_reg >> 1;
            if (sts.mul_done) begin
                rem_reg  <= {1'b0, acc1_next};
                pden_reg <= acc2_next;
                iter_reg <= '0;
            end else begin
                iter_reg <= iter_reg + ITW'(1);
            end
        end
        if (cmd.div) begin
            rem_reg  <= rem_sub << 1;
            d_reg    <= {d_reg[DIV_STEPS-2:0], ge};
            iter_reg <= iter_reg + ITW'(1);
            if (sts.div_done) begin
                q_reg    <= '0;
                sbit_reg <= 16'h8000;
            end
        end
        if (cmd.sqrt) begin
            if (32'(q_try) * 32'(q_try) <= 32'(d_reg)) begin
                q_reg <= q_try;
            end
            sbit_reg <= sbit_reg >> 1;
        end
        if (cmd.load_out) begin
            res.score <= score;
            res.pos_x <= 10'(x0_reg);
            res.pos_y <= y0_reg;
            res.flat  <= flat_reg;
            res.last  <= last_reg;
        end
    end

    assign sts.win        = win;
    assign sts.sweep_done = !iss_reg && !rdv_reg;
    assign sts.flat       = flat_reg;
    assign sts.mul_done   = iter_reg == ITW'(PW - 1);
    assign sts.div_done   = iter_reg == ITW'(DIV_STEPS - 1);
    assign sts.sqrt_done  = sbit_reg[0];

endmodule

`default_nettype wire

// ----- rtl/ntm_ctrl.sv -----
// Controller state machine sequencing the window evaluation.
`default_nettype none

module ntm_ctrl import ntm_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    ntm_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.win) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sts.sweep_done) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL: begin
                if (sts.flat) begin
                    state_next = ST_RESULT;
                end else if (sts.mul_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sts.sqrt_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_SWEEP:  cmd.sweep = 1'b1;
            ST_CALC:   cmd.calc  = 1'b1;
            ST_DIFF:   cmd.diff  = 1'b1;
            ST_MUL:    cmd.mul   = !sts.flat;
            ST_DIV:    cmd.div   = 1'b1;
            ST_SQRT:   cmd.sqrt  = 1'b1;
            ST_RESULT: cmd.load_out = !m_valid_reg || m_ready;
            default:   cmd = '0;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/ncc_template_match.sv -----
// Top level of the zero-mean NCC template matcher.
//
//  port group  dir  payload               transaction when
//  s_*         in   in_item_t (cmd,pixel) s_valid & s_ready
//  m_*         out  out_item_t            m_valid & m_ready
//  cfg_*       in   cfg_index, cfg_data   cfg_valid & cfg_ready
//
// Template pixels and image pixels without a complete window leave the controller idle and ready.
// A window then runs a sweep over one memory read port, the products, a shift-add multiplier,
// a divider, a square root and the output load before the next pixel is taken.
// A flat window skips the multiplier, divider and square root.
// Reset is synchronous; config returns to 8x8 template and 640x480 image.
// The result sits in an output register; a new pixel is taken while it waits.
// A second window stalls the input until that register is free.
`default_nettype none

module ncc_template_match import ntm_pkg::*; #(
    parameter int MAX_TEMPLATE_WIDTH  = 16,
    parameter int MAX_TEMPLATE_HEIGHT = 16,
    parameter int MAX_IMAGE_WIDTH     = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    ntm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ntm_datapath #(
        .MAX_TEMPLATE_WIDTH  (MAX_TEMPLATE_WIDTH),
        .MAX_TEMPLATE_HEIGHT (MAX_TEMPLATE_HEIGHT),
        .MAX_IMAGE_WIDTH     (MAX_IMAGE_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .res       (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/tb_ncc_template_match.sv -----
// Self-checking testbench for the NCC template matcher: directed table, then randomized frames.
`default_nettype none

module tb_ncc_template_match;
    import ntm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  code;
        logic [15:0] value;
        logic        typed;
        out_item_t   want;
    } stim_row_t;

    localparam int NUM_ROWS = 23;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;

    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_CFG, CFG_TEMPLATE_WIDTH,  16'd1, 1'b0, '0},
        '{ROW_CFG, CFG_TEMPLATE_HEIGHT, 16'd1, 1'b0, '0},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd50,  1'b0, '0},
        '{ROW_PIX, 8'(CMD_TEMPLATE), 16'd200, 1'b0, '0},
        '{ROW_PIX, 8'(CMD_TEMPLATE), 16'd3,   1'b0, '0},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd0,   1'b1, '{16'sd0, 10'd1, 12'd0, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_TEMPLATE_WIDTH,  16'd2, 1'b0, '0},
        '{ROW_CFG, CFG_IMAGE_WIDTH,     16'd2, 1'b0, '0},
        '{ROW_CFG, CFG_IMAGE_HEIGHT,    16'd1, 1'b0, '0},
        '{ROW_PIX, 8'(CMD_TEMPLATE), 16'd0,   1'b0, '0},
        '{ROW_PIX, 8'(CMD_TEMPLATE), 16'd255, 1'b0, '0},
        '{ROW_PIX, 8'(CMD_TEMPLATE), 16'd7,   1'b0, '0},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd0,   1'b0, '0},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd255, 1'b1, '{16'sd32767, 10'd0, 12'd0, 1'b0, 1'b1}},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd255, 1'b0, '0},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd0,   1'b1, '{16'h8000, 10'd0, 12'd0, 1'b0, 1'b1}},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd9,   1'b0, '0},
        '{ROW_PIX, 8'(CMD_IMAGE),    16'd9,   1'b1, '{16'sd0, 10'd0, 12'd0, 1'b1, 1'b1}},
        '{ROW_CFG, 8'd5,                16'd3, 1'b0, '0},
        '{ROW_CFG, CFG_TEMPLATE_WIDTH,  16'd31, 1'b0, '0},
        '{ROW_CFG, CFG_TEMPLATE_HEIGHT, 16'd0, 1'b0, '0},
        '{ROW_CFG, CFG_IMAGE_WIDTH,     16'd2047, 1'b0, '0},
        '{ROW_CFG, CFG_IMAGE_HEIGHT,    16'd4095, 1'b0, '0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    ncc_template_match DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predicted state
    int unsigned reg_tw, reg_th, reg_iw, reg_ih;
    logic [7:0]  tmpl_mem [256];
    logic [7:0]  line_mem [16384];
    int unsigned tmpl_cnt, col_cnt, row_cnt;
    longint      tmpl_sum, tmpl_sq_sum;

    out_item_t   window_q [$];
    int          mismatches = 0;
    int          idle_mode = 0;   // 0: sender 18%, receiver 81%; 1: swapped; 2: none
    int          items_sent = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // largest q with q*q*vt*vw <= mag*mag*2^30, capped at 32768
    function automatic int unsigned corr_q15(logic [127:0] mag, logic [127:0] vt,
                                             logic [127:0] vw);
        logic [127:0] lhs, rhs, cand;
        int unsigned  q;
        lhs = (mag * mag) << 30;
        rhs = vt * vw;
        q = 0;
        for (int b = 15; b >= 0; b--) begin
            cand = 128'(q | (1 << b));
            if (rhs * cand * cand <= lhs) q = q | (1 << b);
        end
        return (q > 32768) ? 32768 : q;
    endfunction

    task automatic apply_cfg(input logic [7:0] idx, input logic [15:0] val);
        if (idx == CFG_TEMPLATE_WIDTH) reg_tw = val[4:0];
        else if (idx == CFG_TEMPLATE_HEIGHT) reg_th = val[4:0];
        else if (idx == CFG_IMAGE_WIDTH) reg_iw = val[10:0];
        else if (idx == CFG_IMAGE_HEIGHT) reg_ih = val[11:0];
        else return;
        if (idx == CFG_TEMPLATE_WIDTH || idx == CFG_TEMPLATE_HEIGHT) begin
            tmpl_cnt = 0;
            tmpl_sum = 0;
            tmpl_sq_sum = 0;
        end
        col_cnt = 0;
        row_cnt = 0;
    endtask

    task automatic ncc_predict(input in_item_t px, output bit hit, output out_item_t res);
        int unsigned tw, th, iw, ih, n, x0, y0, q;
        longint      sw, sww, stw, num, vt, vw, w, t;
        tw = clamp_dim(reg_tw, 16);
        th = clamp_dim(reg_th, 16);
        iw = clamp_dim(reg_iw, 1024);
        ih = clamp_dim(reg_ih, 4095);
        n = tw * th;
        hit = 1'b0;
        res = '0;
        if (px.cmd == CMD_TEMPLATE) begin
            if (tmpl_cnt < n) begin
                tmpl_mem[tmpl_cnt] = px.pixel;
                tmpl_sum += px.pixel;
                tmpl_sq_sum += px.pixel * px.pixel;
                tmpl_cnt++;
            end
            return;
        end
        line_mem[(row_cnt % 16) * 1024 + col_cnt % 1024] = px.pixel;
        if (tmpl_cnt >= n && col_cnt + 1 >= tw && row_cnt + 1 >= th) begin
            x0 = col_cnt + 1 - tw;
            y0 = row_cnt + 1 - th;
            sw = 0; sww = 0; stw = 0;
            for (int ty = 0; ty < th; ty++) begin
                for (int tx = 0; tx < tw; tx++) begin
                    w = line_mem[((y0 + ty) % 16) * 1024 + (x0 + tx) % 1024];
                    t = tmpl_mem[ty * tw + tx];
                    sw += w;
                    sww += w * w;
                    stw += w * t;
                end
            end
            num = n * stw - tmpl_sum * sw;
            vt = n * tmpl_sq_sum - tmpl_sum * tmpl_sum;
            vw = n * sww - sw * sw;
            if (vt <= 0 || vw <= 0) begin
                res.flat = 1'b1;
            end else if (num >= 0) begin
                q = corr_q15(128'(num), 128'(vt), 128'(vw));
                res.score = 16'((q > 32767) ? 32767 : q);
            end else begin
                q = corr_q15(128'(-num), 128'(vt), 128'(vw));
                res.score = 16'(-int'(q));
            end
            res.pos_x = 10'(x0);
            res.pos_y = 12'(y0);
            res.last = (col_cnt + 1 >= iw && row_cnt + 1 >= ih);
            hit = 1'b1;
        end
        if (col_cnt + 1 >= iw) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= ih) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endtask

    task automatic send_pixel(input logic cmd, input logic [7:0] pix,
                              input bit typed, input out_item_t want);
        in_item_t  px;
        bit        hit;
        out_item_t res;
        int        pct;
        pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 81 : 0;
        if ($urandom_range(99) < pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        px.cmd = cmd;
        px.pixel = pix;
        s_valid <= 1'b1;
        s_data <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ncc_predict(px, hit, res);
        if (hit) window_q = {window_q, (typed ? want : res)};
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (window_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_cfg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] gen_pixel(int style, logic [7:0] base);
        case (style)
            0: return 8'($urandom_range(255));
            1: return base + 8'($urandom_range(3));
            2: return base;
            default: return $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // receiver and result checker
    always @(posedge aclk) begin
        int pct;
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (window_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                mismatches++;
            end else begin
                want = window_q.pop_front();
                if (m_data.score !== want.score)
                    $display("%0t: score expected %0d got %0d", $time, want.score, m_data.score);
                if (m_data.pos_x !== want.pos_x)
                    $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, m_data.pos_x);
                if (m_data.pos_y !== want.pos_y)
                    $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, m_data.pos_y);
                if (m_data.flat !== want.flat)
                    $display("%0t: flat expected %0b got %0b", $time, want.flat, m_data.flat);
                if (m_data.last !== want.last)
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_data.last);
                if (m_data !== want) mismatches++;
            end
        end
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        pct = (idle_mode == 0) ? 81 : (idle_mode == 1) ? 18 : 0;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready) ||
                         (cfg_valid && cfg_ready))) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    initial begin
        int unsigned tw, th, iw, ih, frames, style, noise;
        logic [7:0]  base;
        reg_tw = 8; reg_th = 8; reg_iw = 640; reg_ih = 480;
        tmpl_cnt = 0; tmpl_sum = 0; tmpl_sq_sum = 0;
        col_cnt = 0; row_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_reg(DIRECTED[i].code, DIRECTED[i].value);
            else
                send_pixel(DIRECTED[i].code[0], DIRECTED[i].value[7:0],
                           DIRECTED[i].typed, DIRECTED[i].want);
        end
        // clamped 16x1 template on a 1024-wide image
        for (int i = 0; i < 16; i++) send_pixel(CMD_TEMPLATE, 8'(i * 17), 1'b0, '0);
        for (int i = 0; i < 20; i++) send_pixel(CMD_IMAGE, 8'($urandom_range(255)), 1'b0, '0);

        // long receiver stall with a 1x1 template so every image pixel yields a window
        write_reg(CFG_TEMPLATE_WIDTH, 16'd1);
        write_reg(CFG_TEMPLATE_HEIGHT, 16'd1);
        write_reg(CFG_IMAGE_WIDTH, 16'd7);
        write_reg(CFG_IMAGE_HEIGHT, 16'd5);
        send_pixel(CMD_TEMPLATE, 8'd90, 1'b0, '0);
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_pixel(CMD_IMAGE, 8'($urandom_range(255)), 1'b0, '0);

        while (items_sent < 550) begin
            idle_mode = (items_sent < 250) ? 0 : (items_sent < 420) ? 1 : 2;
            if ($urandom_range(9) == 0) begin
                tw = $urandom_range(1) ? 0 : $urandom_range(16, 31);
                th = $urandom_range(1, 4);
            end else if ($urandom_range(14) == 0) begin
                tw = 16;
                th = $urandom_range(1) ? 16 : 31;
            end else begin
                tw = $urandom_range(1, 4);
                th = $urandom_range(1, 4);
            end
            iw = clamp_dim(tw, 16) + $urandom_range(0, 5);
            if ($urandom_range(9) == 0) iw = (iw > 2) ? iw - 2 : 0;   // template may end up wider than image
            ih = clamp_dim(th, 16) + $urandom_range(0, 2);
            if ($urandom_range(3) != 0 || items_sent < 60) begin
                write_reg(CFG_TEMPLATE_WIDTH, 16'(tw));
                write_reg(CFG_TEMPLATE_HEIGHT, 16'(th));
                style = $urandom_range(3);
                base = 8'($urandom_range(255));
                for (int i = 0; i < clamp_dim(tw, 16) * clamp_dim(th, 16) + $urandom_range(2) &&
                                items_sent < 550; i++)
                    send_pixel(CMD_TEMPLATE, gen_pixel(style, base), 1'b0, '0);
            end
            write_reg(CFG_IMAGE_WIDTH, 16'(iw));
            write_reg(CFG_IMAGE_HEIGHT, 16'(ih));
            frames = $urandom_range(1, 2);
            style = $urandom_range(3);
            base = 8'($urandom_range(255));
            for (int i = 0; i < frames * clamp_dim(iw, 1024) * clamp_dim(ih, 4095) &&
                            items_sent < 550; i++) begin
                noise = $urandom_range(19);
                if (noise == 0) send_pixel(CMD_TEMPLATE, 8'($urandom_range(255)), 1'b0, '0);
                send_pixel(CMD_IMAGE, gen_pixel(style, base), 1'b0, '0);
            end
            if ($urandom_range(3) == 0) drain();
        end

        drain();
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && window_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- ncc_template_match.f -----
rtl/ntm_pkg.sv
rtl/ntm_datapath.sv
rtl/ntm_ctrl.sv
rtl/ncc_template_match.sv
sim/tb_ncc_template_match.sv
